// ----- rtl/core/knn_pkg.sv -----
// knn_pkg: request codes, register indexes, metric codes, port widths and
// the scan pipeline tag shared by the classifier top level and its distance unit.
// No dependencies.
package knn_pkg;

    // port widths fixed by the interface
    localparam int REQ_W       = 2;
    localparam int LABEL_W     = 4;
    localparam int VOTES_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int METRIC_W    = 2;

    // request types
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TRAIN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NEIGHBOR_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISTANCE_METRIC = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEATURE_COUNT   = 2'd2;

    // distance metrics, any other code acts as chebyshev
    localparam logic [METRIC_W-1:0] MET_EUCLID    = 2'd0;
    localparam logic [METRIC_W-1:0] MET_MANHATTAN = 2'd1;
    localparam logic [METRIC_W-1:0] MET_CHEBYSHEV = 2'd2;

    // tag that travels with each feature through the scan pipeline
    typedef struct packed {
        logic v;      // feature pair present
        logic first;  // first feature of a sample
        logic last;   // last feature of a sample
        logic fin;    // last feature of the last sample
    } knn_tag_t;

endpackage

// ----- rtl/core/knn_dist_unit.sv -----
// knn_dist_unit: three-stage distance pipeline (abs difference, square,
// accumulate) that turns feature pairs into one distance per sample.
// Depends on knn_pkg.
module knn_dist_unit #(
    parameter int VALUE_WIDTH  = 16,
    parameter int MAX_FEATURES = 16,
    parameter int LBL_W        = 4,
    parameter int DIST_W       = 36
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  knn_pkg::knn_tag_t                 in_tag,
    input  logic [knn_pkg::METRIC_W-1:0]      metric,
    input  logic signed [VALUE_WIDTH-1:0]     query_val,
    input  logic signed [VALUE_WIDTH-1:0]     sample_val,
    input  logic [LBL_W-1:0]                  in_label,
    output knn_pkg::knn_tag_t                 out_tag,
    output logic [DIST_W-1:0]                 out_dist,
    output logic [LBL_W-1:0]                  out_label
);
    import knn_pkg::*;

    localparam int AW = VALUE_WIDTH + 1;
    localparam int TW = 2 * AW;
    localparam int DA = TW + $clog2(MAX_FEATURES + 1);

    logic signed [AW-1:0] diff;
    logic [AW-1:0]        abs_next;
    logic [AW-1:0]        abs_reg;
    knn_tag_t             tag_a_reg;
    logic [LBL_W-1:0]     label_a_reg;
    logic [TW-1:0]        term_next;
    logic [TW-1:0]        term_reg;
    knn_tag_t             tag_b_reg;
    logic [LBL_W-1:0]     label_b_reg;
    logic [DA-1:0]        term_ext;
    logic [DA-1:0]        acc_next;
    logic [DA-1:0]        acc_reg;
    logic [DIST_W-1:0]    dist_sat;
    knn_tag_t             out_tag_reg;
    logic [DIST_W-1:0]    out_dist_reg;
    logic [LBL_W-1:0]     out_label_reg;

    // absolute difference of the two features
    assign diff     = {query_val[VALUE_WIDTH-1], query_val}
                    - {sample_val[VALUE_WIDTH-1], sample_val};
    assign abs_next = diff[AW-1] ? AW'(-diff) : AW'(diff);

    // square for euclidean, plain value otherwise
    always_comb begin
        if (metric == MET_EUCLID) begin
            term_next = abs_reg * abs_reg;
        end else begin
            term_next = TW'(abs_reg);
        end
    end

    // accumulate by metric
    assign term_ext = DA'(term_reg);
    always_comb begin
        if (tag_b_reg.first) begin
            acc_next = term_ext;
        end else if (metric == MET_EUCLID || metric == MET_MANHATTAN) begin
            acc_next = acc_reg + term_ext;
        end else if (term_ext > acc_reg) begin
            acc_next = term_ext;
        end else begin
            acc_next = acc_reg;
        end
    end

    // saturate to the stored distance width
    generate
        if (DA > DIST_W) begin : g_sat
            assign dist_sat = (|acc_next[DA-1:DIST_W]) ? {DIST_W{1'b1}}
                                                       : acc_next[DIST_W-1:0];
        end else begin : g_nosat
            assign dist_sat = DIST_W'(acc_next);
        end
    endgenerate

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg   <= '0;
            tag_b_reg   <= '0;
            out_tag_reg <= '0;
        end else begin
            tag_a_reg       <= in_tag;
            tag_b_reg       <= tag_a_reg;
            out_tag_reg.v     <= tag_b_reg.v && tag_b_reg.last;
            out_tag_reg.first <= 1'b0;
            out_tag_reg.last  <= tag_b_reg.v && tag_b_reg.last;
            out_tag_reg.fin   <= tag_b_reg.v && tag_b_reg.fin;
        end
    end

    // pipeline data
    always_ff @(posedge aclk) begin
        abs_reg     <= abs_next;
        label_a_reg <= in_label;
        term_reg    <= term_next;
        label_b_reg <= label_a_reg;
        if (tag_b_reg.v) begin
            acc_reg <= acc_next;
        end
        if (tag_b_reg.v && tag_b_reg.last) begin
            out_dist_reg  <= dist_sat;
            out_label_reg <= label_b_reg;
        end
    end

    assign out_tag   = out_tag_reg;
    assign out_dist  = out_dist_reg;
    assign out_label = out_label_reg;

endmodule

// ----- rtl/core/knn_classifier_unit.sv -----
// Operation: clear and train requests act when taken; a query feature completing the
// vector scans each feature of each stored sample (one feature memory read per cycle)
// through the read registers and distance pipeline, then votes per class and outputs.
// Throughput: one request per cycle outside a query; no request is taken during scan,
// vote or output of a query, and the output waits while an earlier result is stalled.
// Reset: synchronous active-low aresetn empties the table and positions and loads
// register defaults; sample and query memories are not cleared, no clearing pass.
module knn_classifier_unit #(
    parameter int MAX_SAMPLES  = 1024,
    parameter int MAX_FEATURES = 16,
    parameter int MAX_K        = 16,
    parameter int NUM_CLASSES  = 16,
    parameter int VALUE_WIDTH  = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [knn_pkg::REQ_W-1:0]          s_req_type,
    input  logic signed [VALUE_WIDTH-1:0]      s_feature_value,
    input  logic [knn_pkg::LABEL_W-1:0]        s_class_label,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [knn_pkg::LABEL_W-1:0]        m_predicted_class,
    output logic [knn_pkg::VOTES_W-1:0]        m_winning_votes,
    output logic                               m_table_empty,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [knn_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [knn_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import knn_pkg::*;

    localparam int SIW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SW   = $clog2(MAX_SAMPLES + 1);
    localparam int FW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int FW1  = $clog2(MAX_FEATURES + 1);
    localparam int KW   = $clog2(MAX_K + 1);
    localparam int LW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CW   = $clog2(NUM_CLASSES + 1);
    localparam int DEPTH = MAX_SAMPLES * MAX_FEATURES;
    localparam int MAW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DA   = 2 * (VALUE_WIDTH + 1) + $clog2(MAX_FEATURES + 1);
    localparam int DS   = (DA > 64) ? 64 : DA;
    localparam logic [MAW-1:0] MF = MAW'(MAX_FEATURES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_VOTE = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // configuration registers
    logic [CFG_DATA_W-1:0] k_cfg_reg;
    logic [METRIC_W-1:0]   metric_reg;
    logic [CFG_DATA_W-1:0] nf_cfg_reg;

    // table and position state
    logic [SW-1:0]  stored_reg;
    logic [FW-1:0]  load_pos_reg;
    logic [FW-1:0]  query_pos_reg;
    logic [1:0]     state_reg;

    // memories
    logic signed [VALUE_WIDTH-1:0] feat_mem [DEPTH];
    logic [LW-1:0]                 label_mem [MAX_SAMPLES];
    logic signed [VALUE_WIDTH-1:0] query_mem [MAX_FEATURES];
    logic signed [VALUE_WIDTH-1:0] feat_rd_reg;
    logic signed [VALUE_WIDTH-1:0] query_rd_reg;
    logic [LW-1:0]                 label_rd_reg;

    // scan issue
    logic           issuing_reg;
    logic [SIW-1:0] sidx_reg;
    logic [FW-1:0]  fidx_reg;
    knn_tag_t       issue_tag;
    knn_tag_t       rd_tag_reg;
    knn_tag_t       dist_tag;
    logic [DS-1:0]  dist_val;
    logic [LW-1:0]  dist_label;

    // nearest list
    logic [KW-1:0]  k_eff_reg;
    logic [MAX_K-1:0] lv_reg;
    logic [DS-1:0]    ld_reg [MAX_K];
    logic [LW-1:0]    ll_reg [MAX_K];
    logic [MAX_K-1:0] gt;

    // vote
    logic [LW-1:0]  class_reg;
    logic [LW-1:0]  best_label_reg;
    logic [KW-1:0]  best_votes_reg;
    logic [KW-1:0]  vote_cnt;

    // output register
    logic                m_valid_reg;
    logic [LABEL_W-1:0]  m_class_reg;
    logic [VOTES_W-1:0]  m_votes_reg;
    logic                m_empty_reg;

    logic           s_fire;
    logic [FW1-1:0] nf_eff;
    logic [KW-1:0]  k_clamp;
    logic [LW-1:0]  label_sat;
    logic           load_done;
    logic           query_done;
    logic           table_full;
    logic [MAW-1:0] wr_addr;
    logic [MAW-1:0] rd_addr;
    logic           issue_last;
    logic           issue_fin;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;

    // effective feature count and k
    always_comb begin
        if (nf_cfg_reg == '0) begin
            nf_eff = FW1'(1);
        end else if (32'(nf_cfg_reg) > MAX_FEATURES) begin
            nf_eff = FW1'(MAX_FEATURES);
        end else begin
            nf_eff = FW1'(nf_cfg_reg);
        end
        if (k_cfg_reg == '0) begin
            k_clamp = KW'(1);
        end else if (32'(k_cfg_reg) > MAX_K) begin
            k_clamp = KW'(MAX_K);
        end else begin
            k_clamp = KW'(k_cfg_reg);
        end
    end

    // label saturation
    always_comb begin
        if (32'(s_class_label) >= NUM_CLASSES) begin
            label_sat = LW'(NUM_CLASSES - 1);
        end else begin
            label_sat = LW'(s_class_label);
        end
    end

    assign table_full = (32'(stored_reg) >= MAX_SAMPLES);
    assign load_done  = (FW1'(load_pos_reg) + FW1'(1)) >= nf_eff;
    assign query_done = (FW1'(query_pos_reg) + FW1'(1)) >= nf_eff;
    assign wr_addr    = MAW'(stored_reg[SIW-1:0]) * MF + MAW'(load_pos_reg);
    assign rd_addr    = MAW'(sidx_reg) * MF + MAW'(fidx_reg);
    assign issue_last = (FW1'(fidx_reg) + FW1'(1)) >= nf_eff;
    assign issue_fin  = issue_last && (SW'(sidx_reg) + SW'(1) == stored_reg);

    always_comb begin
        issue_tag.v     = issuing_reg;
        issue_tag.first = (fidx_reg == '0);
        issue_tag.last  = issue_last;
        issue_tag.fin   = issue_fin;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_cfg_reg  <= CFG_DATA_W'(1);
            metric_reg <= MET_EUCLID;
            nf_cfg_reg <= CFG_DATA_W'(16);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_NEIGHBOR_COUNT:  k_cfg_reg  <= cfg_data;
                CFG_DISTANCE_METRIC: metric_reg <= cfg_data[METRIC_W-1:0];
                CFG_FEATURE_COUNT:   nf_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sample feature memory
    always_ff @(posedge aclk) begin
        if (s_fire && s_req_type == REQ_TRAIN && !table_full) begin
            feat_mem[wr_addr] <= s_feature_value;
        end
        if (issuing_reg) begin
            feat_rd_reg <= feat_mem[rd_addr];
        end
    end

    // sample label memory
    always_ff @(posedge aclk) begin
        if (s_fire && s_req_type == REQ_TRAIN && !table_full && load_done) begin
            label_mem[stored_reg[SIW-1:0]] <= label_sat;
        end
        if (issuing_reg) begin
            label_rd_reg <= label_mem[sidx_reg];
        end
    end

    // query vector memory
    always_ff @(posedge aclk) begin
        if (s_fire && s_req_type == REQ_QUERY) begin
            query_mem[query_pos_reg] <= s_feature_value;
        end
        if (issuing_reg) begin
            query_rd_reg <= query_mem[fidx_reg];
        end
    end

    knn_dist_unit #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .MAX_FEATURES (MAX_FEATURES),
        .LBL_W        (LW),
        .DIST_W       (DS)
    ) u_dist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_tag     (rd_tag_reg),
        .metric     (metric_reg),
        .query_val  (query_rd_reg),
        .sample_val (feat_rd_reg),
        .in_label   (label_rd_reg),
        .out_tag    (dist_tag),
        .out_dist   (dist_val),
        .out_label  (dist_label)
    );

    // insertion position flags, true from the insert point on
    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            gt[i] = !lv_reg[i] || (ld_reg[i] > dist_val);
        end
    end

    // vote count for the current class
    always_comb begin
        vote_cnt = '0;
        for (int i = 0; i < MAX_K; i++) begin
            if (lv_reg[i] && ll_reg[i] == class_reg) begin
                vote_cnt = vote_cnt + KW'(1);
            end
        end
    end

    // nearest list payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCAN && dist_tag.v) begin
            for (int i = 0; i < MAX_K; i++) begin
                if (gt[i] && KW'(i) < k_eff_reg) begin
                    if (i == 0 || !gt[(i == 0) ? 0 : i - 1]) begin
                        ld_reg[i] <= dist_val;
                        ll_reg[i] <= dist_label;
                    end else begin
                        ld_reg[i] <= ld_reg[(i == 0) ? 0 : i - 1];
                        ll_reg[i] <= ll_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end
    end

    // main control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            stored_reg     <= '0;
            load_pos_reg   <= '0;
            query_pos_reg  <= '0;
            issuing_reg    <= 1'b0;
            rd_tag_reg     <= '0;
            lv_reg         <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            rd_tag_reg <= issue_tag;
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        case (s_req_type)
                            REQ_CLEAR: begin
                                stored_reg   <= '0;
                                load_pos_reg <= '0;
                            end
                            REQ_TRAIN: begin
                                if (load_done) begin
                                    load_pos_reg <= '0;
                                    if (!table_full) begin
                                        stored_reg <= stored_reg + SW'(1);
                                    end
                                end else begin
                                    load_pos_reg <= load_pos_reg + FW'(1);
                                end
                            end
                            REQ_QUERY: begin
                                if (query_done) begin
                                    query_pos_reg <= '0;
                                    lv_reg        <= '0;
                                    sidx_reg      <= '0;
                                    fidx_reg      <= '0;
                                    class_reg     <= '0;
                                    best_label_reg <= '0;
                                    best_votes_reg <= '0;
                                    if (32'(k_clamp) > 32'(stored_reg)) begin
                                        k_eff_reg <= KW'(stored_reg);
                                    end else begin
                                        k_eff_reg <= k_clamp;
                                    end
                                    if (stored_reg == '0) begin
                                        state_reg <= ST_OUT;
                                    end else begin
                                        issuing_reg <= 1'b1;
                                        state_reg   <= ST_SCAN;
                                    end
                                end else begin
                                    query_pos_reg <= query_pos_reg + FW'(1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    // feature read issue
                    if (issuing_reg) begin
                        if (issue_last) begin
                            fidx_reg <= '0;
                            sidx_reg <= sidx_reg + SIW'(1);
                        end else begin
                            fidx_reg <= fidx_reg + FW'(1);
                        end
                        if (issue_fin) begin
                            issuing_reg <= 1'b0;
                        end
                    end
                    // insert the finished distance
                    if (dist_tag.v) begin
                        for (int i = 0; i < MAX_K; i++) begin
                            if (gt[i] && KW'(i) < k_eff_reg) begin
                                if (i == 0 || !gt[(i == 0) ? 0 : i - 1]) begin
                                    lv_reg[i] <= 1'b1;
                                end else begin
                                    lv_reg[i] <= lv_reg[(i == 0) ? 0 : i - 1];
                                end
                            end
                        end
                        if (dist_tag.fin) begin
                            state_reg <= ST_VOTE;
                        end
                    end
                end
                ST_VOTE: begin
                    // one class a cycle, strict compare keeps the smallest label
                    if (vote_cnt > best_votes_reg) begin
                        best_votes_reg <= vote_cnt;
                        best_label_reg <= class_reg;
                    end
                    if (CW'(class_reg) + CW'(1) >= CW'(NUM_CLASSES)) begin
                        state_reg <= ST_OUT;
                    end else begin
                        class_reg <= class_reg + LW'(1);
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_class_reg <= LABEL_W'(best_label_reg);
                        m_votes_reg <= VOTES_W'(best_votes_reg);
                        m_empty_reg <= (stored_reg == '0);
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_predicted_class = m_class_reg;
    assign m_winning_votes   = m_votes_reg;
    assign m_table_empty     = m_empty_reg;

`ifndef SYNTHESIS
    // table never holds more than its capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(stored_reg) <= MAX_SAMPLES)
        else $error("stored sample count above capacity");

    // list never holds more than k entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> $countones(lv_reg) <= 32'(k_eff_reg))
        else $error("nearest list over k");

    // a finished scan has exactly k neighbors
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_VOTE |-> $countones(lv_reg) == 32'(k_eff_reg))
        else $error("nearest list not full at vote");

    // empty table result carries no votes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_empty_reg |-> m_votes_reg == '0 && m_class_reg == '0)
        else $error("empty table result with votes");
`endif

endmodule

// ----- test/testbench.sv -----
// testbench for knn_classifier_unit: directed and random training, clear and query requests
// checked against a behavioral k-nearest-neighbour predictor kept in this file
// depends on knn_pkg and the knn_classifier_unit rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import knn_pkg::*;

    localparam int SAMPLE_CAP = 1024;
    localparam int FEAT_CAP   = 16;
    localparam int K_CAP      = 16;
    localparam int CLASS_CNT  = 16;
    localparam logic [REQ_W-1:0]    REQ_UNUSED = 2'd3;
    localparam logic [METRIC_W-1:0] MET_ALIAS  = 2'd3;

    typedef struct {
        logic [REQ_W-1:0]   req;
        logic signed [15:0] value;
        logic [LABEL_W-1:0] label;
    } request_t;

    typedef struct {
        logic [LABEL_W-1:0] cls;
        logic [VOTES_W-1:0] votes;
        logic               empty;
    } verdict_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [REQ_W-1:0] s_req_type = '0;
    logic signed [15:0] s_feature_value = '0;
    logic [LABEL_W-1:0] s_class_label = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [LABEL_W-1:0] m_predicted_class;
    logic [VOTES_W-1:0] m_winning_votes;
    logic m_table_empty;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    knn_classifier_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_feature_value(s_feature_value), .s_class_label(s_class_label),
        .m_valid(m_valid), .m_ready(m_ready), .m_predicted_class(m_predicted_class),
        .m_winning_votes(m_winning_votes), .m_table_empty(m_table_empty),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    logic [4:0]         k_reg = 5'd1;
    logic [1:0]         metric_reg = MET_EUCLID;
    logic [4:0]         nfeat_reg = 5'd16;
    logic signed [15:0] feat_mem [SAMPLE_CAP][FEAT_CAP];
    logic [3:0]         label_mem [SAMPLE_CAP];
    int                 sample_total = 0;
    int                 load_pos = 0;
    logic signed [15:0] query_vec [FEAT_CAP];
    int                 query_pos = 0;

    request_t pending_requests[$];
    verdict_t expected_verdicts[$];
    int       errors = 0;
    bit       calm = 1'b0;

    function automatic int active_features();
        if (nfeat_reg < 1) return 1;
        if (nfeat_reg > FEAT_CAP) return FEAT_CAP;
        return nfeat_reg;
    endfunction

    function automatic longint unsigned sample_distance(int s, int nf);
        longint unsigned acc;
        longint d;
        longint unsigned ad;
        acc = 0;
        for (int f = 0; f < nf; f++) begin
            d = longint'(query_vec[f]) - longint'(feat_mem[s][f]);
            ad = (d < 0) ? longint'(-d) : d;
            if (metric_reg == MET_EUCLID) acc += ad * ad;
            else if (metric_reg == MET_MANHATTAN) acc += ad;
            else if (ad > acc) acc = ad;
        end
        return acc;
    endfunction

    function automatic verdict_t classify();
        verdict_t v;
        longint unsigned near_dist [K_CAP];
        int near_idx [K_CAP];
        int votes [CLASS_CNT];
        int k, held, pos, nf;
        longint unsigned d;
        v.cls = '0;
        v.votes = '0;
        v.empty = 1'b0;
        nf = active_features();
        if (sample_total == 0) begin
            v.empty = 1'b1;
            return v;
        end
        k = (k_reg < 1) ? 1 : ((k_reg > K_CAP) ? K_CAP : k_reg);
        if (k > sample_total) k = sample_total;
        held = 0;
        for (int s = 0; s < sample_total; s++) begin
            d = sample_distance(s, nf);
            if (held == k && d >= near_dist[k-1]) continue;
            if (held < k) held++;
            pos = held - 1;
            // shift farther entries down, equal distances keep the earlier sample
            while (pos > 0 && near_dist[pos-1] > d) begin
                near_dist[pos] = near_dist[pos-1];
                near_idx[pos] = near_idx[pos-1];
                pos--;
            end
            near_dist[pos] = d;
            near_idx[pos] = s;
        end
        foreach (votes[i]) votes[i] = 0;
        for (int i = 0; i < held; i++) votes[label_mem[near_idx[i]]]++;
        for (int i = 0; i < CLASS_CNT; i++) begin
            if (votes[i] > v.votes) begin
                v.votes = VOTES_W'(votes[i]);
                v.cls = LABEL_W'(i);
            end
        end
        return v;
    endfunction

    // update predictor with one accepted request
    function automatic void apply_request(request_t r);
        int nf;
        nf = active_features();
        case (r.req)
            REQ_CLEAR: begin
                sample_total = 0;
                load_pos = 0;
            end
            REQ_TRAIN: begin
                if (sample_total < SAMPLE_CAP) feat_mem[sample_total][load_pos] = r.value;
                if (load_pos + 1 >= nf) begin
                    if (sample_total < SAMPLE_CAP) begin
                        label_mem[sample_total] = r.label;
                        sample_total++;
                    end
                    load_pos = 0;
                end else begin
                    load_pos++;
                end
            end
            REQ_QUERY: begin
                query_vec[query_pos] = r.value;
                if (query_pos + 1 >= nf) begin
                    query_pos = 0;
                    expected_verdicts.push_back(classify());
                end else begin
                    query_pos++;
                end
            end
            default: ;
        endcase
    endfunction

    // request driver
    request_t cur_req;
    int       send_gap = 0;
    logic     next_valid;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                apply_request(cur_req);
                next_valid = 1'b0;
                send_gap = calm ? 0 : $urandom_range(0, 6);
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_requests.size() > 0) begin
                    cur_req = pending_requests.pop_front();
                    next_valid = 1'b1;
                    s_req_type <= cur_req.req;
                    s_feature_value <= cur_req.value;
                    s_class_label <= cur_req.label;
                end
            end
            s_valid <= next_valid;
        end
    end

    // result monitor with random stalls
    int       stall = 0;
    verdict_t want;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result with nothing expected: class %0d", m_predicted_class);
                    errors++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_predicted_class !== want.cls) begin
                        $error("predicted_class expected %0d actual %0d", want.cls,
                               m_predicted_class);
                        errors++;
                    end
                    if (m_winning_votes !== want.votes) begin
                        $error("winning_votes expected %0d actual %0d", want.votes,
                               m_winning_votes);
                        errors++;
                    end
                    if (m_table_empty !== want.empty) begin
                        $error("table_empty expected %0d actual %0d", want.empty,
                               m_table_empty);
                        errors++;
                    end
                end
                stall = calm ? 0 : $urandom_range(0, 6);
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [15:0] draw_value();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 3) - 2);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            2: return 16'($urandom_range(0, 600) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push(logic [REQ_W-1:0] req, logic signed [15:0] value,
                        logic [LABEL_W-1:0] label);
        request_t r;
        r.req = req;
        r.value = value;
        r.label = label;
        pending_requests.push_back(r);
    endtask

    task automatic push_sample(int label_top);
        int nf;
        nf = active_features();
        for (int f = 0; f < nf; f++)
            push(REQ_TRAIN, draw_value(), LABEL_W'($urandom_range(0, label_top)));
    endtask

    task automatic push_query();
        int nf;
        nf = active_features();
        for (int f = 0; f < nf; f++) push(REQ_QUERY, draw_value(), LABEL_W'($urandom));
    endtask

    // wait until every request is taken and every result has come back
    task automatic drain();
        while (pending_requests.size() > 0 || s_valid || expected_verdicts.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain();
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_NEIGHBOR_COUNT:  k_reg = data;
            CFG_DISTANCE_METRIC: metric_reg = data[1:0];
            CFG_FEATURE_COUNT:   nfeat_reg = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // switch settings and start from an empty table
    task automatic set_mode(int k, logic [1:0] metric, int nf);
        write_reg(CFG_NEIGHBOR_COUNT, CFG_DATA_W'(k));
        write_reg(CFG_DISTANCE_METRIC, CFG_DATA_W'(metric));
        write_reg(CFG_FEATURE_COUNT, CFG_DATA_W'(nf));
        push(REQ_CLEAR, draw_value(), LABEL_W'($urandom));
    endtask

    int modes [9][3] = '{
        '{1, MET_EUCLID, 1}, '{16, MET_MANHATTAN, 16}, '{0, MET_CHEBYSHEV, 3},
        '{31, MET_ALIAS, 4}, '{5, MET_EUCLID, 0}, '{20, MET_MANHATTAN, 31},
        '{3, MET_CHEBYSHEV, 8}, '{7, MET_EUCLID, 2}, '{2, MET_MANHATTAN, 5}
    };
    int label_top;

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, noise, extremes, distance ties, clear
        set_mode(3, MET_MANHATTAN, 2);
        push(REQ_QUERY, 16'sh7fff, 4'd0);
        push(REQ_QUERY, 16'sh8000, 4'd15);
        push(REQ_UNUSED, 16'sh1234, 4'd9);
        push(REQ_TRAIN, 16'sh7fff, 4'd0);
        push(REQ_TRAIN, 16'sh8000, 4'd15);
        push(REQ_TRAIN, 16'sh0000, 4'd0);
        push(REQ_TRAIN, 16'sh0000, 4'd5);
        push(REQ_TRAIN, 16'sh0000, 4'd0);
        push(REQ_TRAIN, 16'sh0000, 4'd3);
        push(REQ_QUERY, 16'sh0000, 4'd0);
        push(REQ_QUERY, 16'sh0000, 4'd0);
        push(REQ_QUERY, 16'sh7fff, 4'd0);
        push(REQ_QUERY, 16'sh8000, 4'd0);
        push(REQ_CLEAR, 16'sh0000, 4'd0);
        push(REQ_QUERY, 16'sh0001, 4'd0);
        push(REQ_QUERY, 16'sh0001, 4'd0);

        // feature count lowered while a query vector is partly filled
        set_mode(2, MET_EUCLID, 4);
        repeat (3) push_sample(15);
        for (int f = 0; f < 3; f++) push(REQ_QUERY, draw_value(), 4'd0);
        write_reg(CFG_FEATURE_COUNT, 2);
        push(REQ_QUERY, draw_value(), 4'd0);

        // random phases over a spread of settings
        foreach (modes[m]) begin
            set_mode(modes[m][0], METRIC_W'(modes[m][1]), modes[m][2]);
            calm = (m % 3 == 2);
            label_top = $urandom_range(0, 1) ? 3 : 15;
            for (int n = 0; n < 10; n++) begin
                case ($urandom_range(0, 9))
                    0: push(REQ_CLEAR, draw_value(), LABEL_W'($urandom));
                    1: push(REQ_UNUSED, draw_value(), LABEL_W'($urandom));
                    2, 3, 4: push_query();
                    default: push_sample(label_top);
                endcase
            end
            push_query();
        end

        drain();
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
